### rtl/bcd_pkg.sv
// Package: shared widths, constants and controller/datapath handshake types.
package bcd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int TIME_W    = 32;
  localparam int LOCKOUT_W = 10;
  localparam int NUM_W     = 5;
  localparam int IDX_W     = 4;

  localparam logic [SAMPLE_W-1:0]  ALL_RELEASED  = 16'hFFFF;
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 10'd30;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic emit;
  } bcd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic accept_ok;
    logic pend_last;
    logic out_free;
  } bcd_status_t;

endpackage

### rtl/bcd_in_if.sv
// Interface: input sample channel (valid/ready with sample and timestamp).
interface bcd_in_if
  import bcd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] button_sample;
  logic [TIME_W-1:0]   time_ms;

  modport source (output valid, output button_sample, output time_ms, input ready);
  modport sink   (input valid, input button_sample, input time_ms, output ready);
endinterface

### rtl/bcd_out_if.sv
// Interface: change event channel (valid/ready with event fields).
interface bcd_out_if
  import bcd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] button_number;
  logic             pressed;
  logic             last_of_run;

  modport source (output valid, output button_number, output pressed, output last_of_run,
                  input ready);
  modport sink   (input valid, input button_number, input pressed, input last_of_run,
                  output ready);
endinterface

### rtl/bcd_ctrl.sv
// Controller: sequences capture, lockout check and per-button event emission.
module bcd_ctrl
  import bcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  bcd_status_t status,
  output bcd_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Decode commands and next state
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.load    = 1'b0;
    cmd.emit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.accept_ok) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.pend_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("controller state not one-hot");
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
      (cmd.emit && status.pend_last) |=> in_ready)
    else $error("controller did not return to idle after last event");
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == ST_CHECK && !status.accept_ok) |=> in_ready)
    else $error("rejected sample did not release input");

endmodule

### rtl/bcd_dp.sv
// Datapath: accepted levels, lockout timing, pending change mask and event register.
module bcd_dp
  import bcd_pkg::*;
#(
  parameter int BUTTON_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bcd_cmd_t             cmd,
  output bcd_status_t          status,
  input  logic [SAMPLE_W-1:0]  in_sample,
  input  logic [TIME_W-1:0]    in_time,
  input  logic                 cfg_we,
  input  logic [LOCKOUT_W-1:0] cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [NUM_W-1:0]     out_number,
  output logic                 out_pressed,
  output logic                 out_last
);

  localparam int ACTIVE = (BUTTON_COUNT >= SAMPLE_W) ? SAMPLE_W : BUTTON_COUNT;
  localparam logic [SAMPLE_W-1:0] ACTIVE_MASK =
    (ACTIVE >= SAMPLE_W) ? ALL_RELEASED : SAMPLE_W'((64'd1 << ACTIVE) - 64'd1);

  logic [SAMPLE_W-1:0]  sample_r;
  logic [TIME_W-1:0]    time_r;
  logic [SAMPLE_W-1:0]  levels_r;
  logic [TIME_W-1:0]    last_time_r;
  logic [LOCKOUT_W-1:0] lockout_r;
  logic [SAMPLE_W-1:0]  pending_r;
  logic                 out_valid_r;
  logic [NUM_W-1:0]     out_number_r;
  logic                 out_pressed_r;
  logic                 out_last_r;

  logic [SAMPLE_W-1:0] changed;
  logic [TIME_W-1:0]   elapsed;
  logic [SAMPLE_W-1:0] pending_rest;
  logic [IDX_W-1:0]    low_idx;

  // Lockout check on the captured sample
  assign changed = (sample_r ^ levels_r) & ACTIVE_MASK;
  assign elapsed = time_r - last_time_r;

  // Find the lowest pending button and the mask left after it
  assign pending_rest = pending_r & (pending_r - SAMPLE_W'(1));
  always_comb begin
    low_idx = '0;
    for (int i = SAMPLE_W - 1; i >= 0; i--) begin
      if (pending_r[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  assign status.accept_ok = (changed != '0) &&
                            (elapsed >= {{(TIME_W-LOCKOUT_W){1'b0}}, lockout_r});
  assign status.pend_last = (pending_rest == '0);
  assign status.out_free  = !out_valid_r || out_ready;

  // Capture the incoming transaction, forcing unused buttons to released
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= (in_sample & ACTIVE_MASK) | ~ACTIVE_MASK;
      time_r   <= in_time;
    end
  end

  // Hold the accepted state and lockout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r    <= ALL_RELEASED;
      last_time_r <= '0;
      lockout_r   <= LOCKOUT_RESET;
    end else begin
      if (cfg_we) begin
        lockout_r <= cfg_wdata;
      end
      if (cmd.load) begin
        levels_r    <= sample_r;
        last_time_r <= time_r;
      end
    end
  end

  // Advance the pending change mask
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pending_r <= changed;
    end else if (cmd.emit) begin
      pending_r <= pending_rest;
    end
  end

  // Event output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_number_r  <= NUM_W'(low_idx) + NUM_W'(1);
      out_pressed_r <= ~levels_r[low_idx];
      out_last_r    <= (pending_rest == '0);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_number  = out_number_r;
  assign out_pressed = out_pressed_r;
  assign out_last    = out_last_r;

  a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
      cmd.emit |-> (pending_r != '0))
    else $error("event emitted with no pending change");
  a_load_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
      cmd.load |=> (pending_r != '0))
    else $error("accepted sample left no pending change");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
      cmd.emit |=> out_valid_r)
    else $error("emitted event not presented");
  a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
      cmd.load |-> status.accept_ok)
    else $error("sample loaded without passing lockout check");

endmodule

### rtl/button_change_event_debouncer.sv
// Top level: button change-event debouncer with lockout.
// Sequence: a sample is captured at acceptance, checked the next cycle, and, if it
//   passes, its change events are registered on the output one per cycle while the
//   output register is free; the input is not ready again until the last event of the
//   run is emitted or the sample is rejected (N changed buttons give N events).
// Reset (synchronous, active low): levels all released, last time zero, lockout 30 ms.
module button_change_event_debouncer
  import bcd_pkg::*;
#(
  parameter int BUTTON_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bcd_in_if.sink               in_ch,
  bcd_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [LOCKOUT_W-1:0] cfg_wdata
);

  bcd_cmd_t    cmd;
  bcd_status_t status;
  logic        in_ready;

  assign in_ch.ready = in_ready;

  // Sequence each transaction
  bcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold state and build events
  bcd_dp #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_sample   (in_ch.button_sample),
    .in_time     (in_ch.time_ms),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_number  (out_ch.button_number),
    .out_pressed (out_ch.pressed),
    .out_last    (out_ch.last_of_run)
  );

endmodule

### test/debounce_event_checker.sv
`timescale 1ns / 1ps
// Checker for the button debouncer: predicts change events per sample and compares them.
module debounce_event_checker
  import bcd_pkg::*;
#(
  parameter int BUTTON_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bcd_in_if                    in_mon,
  bcd_out_if                   out_mon,
  input  logic                 cfg_we,
  input  logic [LOCKOUT_W-1:0] cfg_wdata,
  output int                   mismatch_count,
  output int                   events_outstanding
);

  typedef struct packed {
    logic [NUM_W-1:0] button_number;
    logic             pressed;
    logic             last_of_run;
  } change_event_t;

  // Sample bits above the button count are not buttons and stay released
  localparam logic [SAMPLE_W-1:0] BUTTON_MASK = (BUTTON_COUNT >= SAMPLE_W) ? ALL_RELEASED :
                                                ALL_RELEASED >> (SAMPLE_W - BUTTON_COUNT);

  logic [LOCKOUT_W-1:0] lockout_ms;
  logic [SAMPLE_W-1:0]  held_levels;
  logic [TIME_W-1:0]    held_time;
  change_event_t        events_due[$];

  // Apply one sample to the predicted state and queue the change events it causes
  function automatic void predict_change_events(input logic [SAMPLE_W-1:0] sample,
                                                input logic [TIME_W-1:0]   now);
    logic [SAMPLE_W-1:0] levels;
    logic [SAMPLE_W-1:0] changed;
    logic [TIME_W-1:0]   elapsed;
    change_event_t       ev;
    levels  = (sample & BUTTON_MASK) | ~BUTTON_MASK;
    changed = (levels ^ held_levels) & BUTTON_MASK;
    // unsigned difference, so a wrapped timestamp still counts forward
    elapsed = now - held_time;
    if (changed == '0 || elapsed < TIME_W'(lockout_ms)) return;
    held_time   = now;
    held_levels = levels;
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (changed[i]) begin
        ev.button_number = NUM_W'(i + 1);
        ev.pressed       = ~levels[i];
        ev.last_of_run   = (changed >> (i + 1)) == '0;
        events_due.push_back(ev);
      end
    end
  endfunction

  always @(posedge clk) begin
    change_event_t want;
    if (!rst_n) begin
      lockout_ms     = LOCKOUT_RESET;
      held_levels    = ALL_RELEASED;
      held_time      = '0;
      mismatch_count = 0;
      events_due.delete();
    end else begin
      // track lockout writes
      if (cfg_we) lockout_ms = cfg_wdata;

      // compare each event transaction with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (events_due.size() == 0) begin
          $display("%0t: unexpected event: button %0d pressed %0b last %0b", $time,
                   out_mon.button_number, out_mon.pressed, out_mon.last_of_run);
          mismatch_count++;
        end else begin
          want = events_due.pop_front();
          if (out_mon.button_number !== want.button_number ||
              out_mon.pressed !== want.pressed ||
              out_mon.last_of_run !== want.last_of_run) begin
            $display("%0t: mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     $time, want.button_number, want.pressed, want.last_of_run,
                     out_mon.button_number, out_mon.pressed, out_mon.last_of_run);
            mismatch_count++;
          end
        end
      end

      // predict from each sample transaction
      if (in_mon.valid && in_mon.ready)
        predict_change_events(in_mon.button_sample, in_mon.time_ms);
    end
    events_outstanding = events_due.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the button debouncer: stimulus, lockout writes, receiver pacing, verdict.
module tb_top;
  import bcd_pkg::*;

  localparam int BUTTONS       = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 110;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [LOCKOUT_W-1:0] cfg_wdata;
  int                   mismatch_count;
  int                   events_outstanding;

  bit                   idling = 1'b1;
  int                   hold_requests = 0;
  int                   holds_served = 0;
  int                   hold_left = 0;
  logic [SAMPLE_W-1:0]  last_sample = ALL_RELEASED;
  logic [TIME_W-1:0]    clock_ms = '0;
  int                   lockout_now = LOCKOUT_RESET;

  bcd_in_if  in_ch ();
  bcd_out_if out_ch ();

  button_change_event_debouncer #(.BUTTON_COUNT(BUTTONS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  debounce_event_checker #(.BUTTON_COUNT(BUTTONS)) event_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mon             (in_ch),
    .out_mon            (out_ch),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .mismatch_count     (mismatch_count),
    .events_outstanding (events_outstanding)
  );

  always #5 clk = ~clk;

  // Pace the event receiver: long hold-offs on request, otherwise random stalls while idling
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idling && $urandom_range(99) < 11) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Offer one sample transaction, with an occasional gap while idling, and hold it until taken
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic [TIME_W-1:0] stamp);
    if (idling && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.button_sample <= sample;
    in_ch.time_ms       <= stamp;
    last_sample = sample;
    clock_ms    = stamp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait for every predicted event, then let a rejected sample finish
  task automatic drain_events();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (events_outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_lockout(input logic [LOCKOUT_W-1:0] value);
    drain_events();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    lockout_now = value;
  endtask

  // Mostly small flips on the last sample with gaps around the lockout, some noise
  task automatic run_random_phase(input int count);
    logic [SAMPLE_W-1:0] flips;
    logic [TIME_W-1:0]   gap_ms;
    int                  pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 55)
        flips = SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1);
      else if (pick < 70)
        flips = (SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1)) |
                (SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1));
      else if (pick < 85)
        flips = SAMPLE_W'($urandom);
      else if (pick < 93)
        flips = '0;
      else
        flips = ALL_RELEASED;
      pick = $urandom_range(99);
      if (pick < 60)
        gap_ms = TIME_W'($urandom_range(0, 2 * lockout_now + 1));
      else if (pick < 90)
        gap_ms = TIME_W'(lockout_now) + TIME_W'($urandom_range(0, 2)) - 1;
      else
        gap_ms = $urandom;
      send_sample(last_sample ^ flips, clock_ms + gap_ms);
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.button_sample <= ALL_RELEASED;
    in_ch.time_ms       <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no change, early samples after reset, lockout edges, all buttons, wrap
    send_sample(16'hFFFF, 32'd0);
    send_sample(16'hFFFE, 32'd10);
    send_sample(16'hFFFE, 32'd30);
    send_sample(16'h0000, 32'd59);
    send_sample(16'h0000, 32'd60);
    send_sample(16'hFFFF, 32'd90);
    send_sample(16'h7FFF, 32'd120);
    send_sample(16'h8000, 32'd150);
    send_sample(16'h5555, 32'd180);
    send_sample(16'hAAAA, 32'd210);
    send_sample(16'hAAAA, 32'd500);
    send_sample(16'h1234, 32'hFFFF_FFF0);
    send_sample(16'h4321, 32'h0000_000D);
    send_sample(16'h4321, 32'h0000_000E);
    write_lockout(10'd0);
    send_sample(16'h4320, 32'h0000_000E);
    send_sample(16'h4321, 32'h0000_000E);
    write_lockout(10'd1023);
    send_sample(16'h4320, 32'h0000_040C);
    send_sample(16'h4320, 32'h0000_040D);

    // Random: longest lockout with the receiver held off at the start
    hold_requests++;
    run_random_phase(PHASE_ITEMS);

    write_lockout(10'd0);
    run_random_phase(PHASE_ITEMS);

    // Random lockout across the timestamp wrap, no idling on either side
    write_lockout(LOCKOUT_W'($urandom_range(1, 1022)));
    clock_ms = 32'hFFFF_F000;
    idling   = 1'b0;
    run_random_phase(PHASE_ITEMS);
    idling   = 1'b1;

    write_lockout(LOCKOUT_RESET);
    hold_requests++;
    run_random_phase(PHASE_ITEMS);

    drain_events();
    if (mismatch_count == 0 && events_outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Stop a hung run
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
